// File: design/bpbf_pkg.sv
// ----------------------------------------------------------------------------
// bpbf_pkg
// Shared constants and controller/datapath types for the best-fit buffer pool.
// ----------------------------------------------------------------------------
package bpbf_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int DATA_W      = 32;
	localparam int COUNT_W     = 6;
	localparam int CFG_IDX_W   = 8;

	localparam logic [DATA_W-1:0] MIN_POOLED_RESET = 32'd1048576;
	localparam logic [DATA_W-1:0] MAX_POOLED_RESET = 32'd671088640;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_POOLED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POOLED = 8'd1;

	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RECYCLE = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic remove;
		logic evict;
		logic append;
		logic result;
	} bpbf_cmd_t;

	typedef struct packed {
		logic start_ok;
		logic start_recycle;
		logic scan_end;
		logic found;
		logic evict_need;
	} bpbf_sts_t;

endpackage

// File: design/bpbf_req_if.sv
// ----------------------------------------------------------------------------
// bpbf_req_if
// Request channel: acquire or recycle word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpbf_req_if
	import bpbf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [DATA_W-1:0] req_size;

	modport source (output valid, output req_type, output req_size, input ready);
	modport sink   (input valid, input req_type, input req_size, output ready);
endinterface

// File: design/bpbf_rsp_if.sv
// ----------------------------------------------------------------------------
// bpbf_rsp_if
// Result channel: one result word per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpbf_rsp_if
	import bpbf_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               reused;
	logic [DATA_W-1:0]  granted_capacity;
	logic               kept;
	logic [COUNT_W-1:0] evicted_count;
	logic [COUNT_W-1:0] entry_count;
	logic [DATA_W-1:0]  pooled_total;

	modport source (
		output valid, output reused, output granted_capacity, output kept,
		output evicted_count, output entry_count, output pooled_total,
		input ready
	);
	modport sink (
		input valid, input reused, input granted_capacity, input kept,
		input evicted_count, input entry_count, input pooled_total,
		output ready
	);
endinterface

// File: design/bpbf_cfg_if.sv
// ----------------------------------------------------------------------------
// bpbf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bpbf_cfg_if
	import bpbf_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/buffer_pool_best_fit.sv
// Flow: an acquire scans every entry held, one per cycle, removes any best fit
// and posts; a kept recycle evicts oldest entries, one per cycle, then appends.
// A rejected word goes straight to posting. Throughput: one word at a time; the
// next word can be accepted in the cycle after the result is posted.
// Reset (arst_n low) empties the pool and restores both configuration registers.
// ----------------------------------------------------------------------------
// buffer_pool_best_fit
// Best-fit free-buffer pool with oldest-first eviction under a byte budget.
// ----------------------------------------------------------------------------
module buffer_pool_best_fit
	import bpbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bpbf_req_if.sink    req,
	bpbf_rsp_if.source  rsp,
	bpbf_cfg_if.sink    cfg
);

	bpbf_cmd_t cmd;
	bpbf_sts_t sts;

	assign cfg.ready = 1'b1;

	bpbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpbf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.in_type     (req.req_type),
		.in_size     (req.req_size),
		.cmd         (cmd),
		.sts         (sts),
		.res_reused  (rsp.reused),
		.res_granted (rsp.granted_capacity),
		.res_kept    (rsp.kept),
		.res_evicted (rsp.evicted_count),
		.res_entries (rsp.entry_count),
		.res_total   (rsp.pooled_total)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous word in progress");

	a_entries_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.entry_count <= COUNT_W'(MAX_ENTRIES))
		else $error("entry count above pool depth");

	a_acquire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.reused |-> !rsp.kept && rsp.evicted_count == '0)
		else $error("acquire result carries recycle fields");

	a_kept_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kept |-> rsp.entry_count != '0 && rsp.granted_capacity == '0)
		else $error("kept recycle left pool empty or granted capacity");
`endif

endmodule

// File: design/bpbf_ctrl.sv
// ----------------------------------------------------------------------------
// bpbf_ctrl
// Sequencer: accept a word, scan or evict through the datapath, post result.
// ----------------------------------------------------------------------------
module bpbf_ctrl
	import bpbf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  bpbf_sts_t  sts,
	output bpbf_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVICT,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				if (!sts.scan_end) begin
					cmd.scan = 1'b1;
				end else begin
					cmd.remove = sts.found;
				end
			end
			ST_EVICT: begin
				if (sts.evict_need) begin
					cmd.evict = 1'b1;
				end else begin
					cmd.append = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.result = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (!sts.start_ok) begin
							state_q <= ST_DONE;
						end else if (sts.start_recycle) begin
							state_q <= ST_EVICT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (sts.scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_EVICT: begin
					if (!sts.evict_need) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.result) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/bpbf_dp.sv
// ----------------------------------------------------------------------------
// bpbf_dp
// Datapath: age-ordered entry list, best-fit scan, compaction, eviction,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module bpbf_dp
	import bpbf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_type,
	input  logic [DATA_W-1:0]    in_size,
	input  bpbf_cmd_t            cmd,
	output bpbf_sts_t            sts,
	output logic                 res_reused,
	output logic [DATA_W-1:0]    res_granted,
	output logic                 res_kept,
	output logic [COUNT_W-1:0]   res_evicted,
	output logic [COUNT_W-1:0]   res_entries,
	output logic [DATA_W-1:0]    res_total
);

	logic [DATA_W-1:0]  slot_q [MAX_ENTRIES];
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  held_q;
	logic [DATA_W-1:0]  min_q;
	logic [DATA_W-1:0]  max_q;

	logic               type_q;
	logic [DATA_W-1:0]  size_q;
	logic [CNT_W-1:0]   idx_q;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [DATA_W-1:0]  best_cap_q;
	logic               kept_q;
	logic [CNT_W-1:0]   evict_q;

	logic               res_reused_q;
	logic [DATA_W-1:0]  res_granted_q;
	logic               res_kept_q;
	logic [COUNT_W-1:0] res_evicted_q;
	logic [COUNT_W-1:0] res_entries_q;
	logic [DATA_W-1:0]  res_total_q;

	logic [DATA_W-1:0]  scan_cap;
	logic               scan_hit;
	logic [DATA_W:0]    held_plus;
	logic               in_acq_ok;
	logic               in_keep_ok;

	assign scan_cap = slot_q[idx_q[IDX_W-1:0]];
	assign scan_hit = (scan_cap >= size_q)
		&& ({1'b0, scan_cap} <= {size_q, 1'b0})
		&& (!found_q || scan_cap < best_cap_q);

	assign held_plus  = {1'b0, held_q} + {1'b0, size_q};
	assign in_acq_ok  = (in_size >= min_q);
	assign in_keep_ok = in_acq_ok && (in_size <= (max_q >> 2));

	assign sts.start_ok      = (in_type == REQ_RECYCLE) ? in_keep_ok : in_acq_ok;
	assign sts.start_recycle = (in_type == REQ_RECYCLE);
	assign sts.scan_end      = (idx_q == count_q);
	assign sts.found         = found_q;
	assign sts.evict_need    = (count_q != '0)
		&& ((count_q >= CNT_W'(MAX_ENTRIES)) || (held_plus > {1'b0, max_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			held_q  <= '0;
			min_q   <= MIN_POOLED_RESET;
			max_q   <= MAX_POOLED_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_POOLED: min_q <= cfg_data;
					REG_MAX_POOLED: max_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.remove) begin
				count_q <= count_q - CNT_W'(1);
				held_q  <= held_q - best_cap_q;
			end else if (cmd.evict) begin
				count_q <= count_q - CNT_W'(1);
				held_q  <= held_q - slot_q[0];
			end else if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
				held_q  <= held_plus[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
			if (cmd.evict || (cmd.remove && IDX_W'(i) >= best_idx_q)) begin
				slot_q[i] <= slot_q[i+1];
			end else if (cmd.append && count_q == CNT_W'(i)) begin
				slot_q[i] <= size_q;
			end
		end
		if (cmd.append && count_q == CNT_W'(MAX_ENTRIES - 1)) begin
			slot_q[MAX_ENTRIES-1] <= size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= in_type;
			size_q  <= in_size;
			idx_q   <= '0;
			found_q <= 1'b0;
			kept_q  <= 1'b0;
			evict_q <= '0;
		end
		if (cmd.scan) begin
			idx_q <= idx_q + CNT_W'(1);
			if (scan_hit) begin
				found_q    <= 1'b1;
				best_idx_q <= idx_q[IDX_W-1:0];
				best_cap_q <= scan_cap;
			end
		end
		if (cmd.evict) begin
			evict_q <= evict_q + CNT_W'(1);
		end
		if (cmd.append) begin
			kept_q <= 1'b1;
		end
		if (cmd.result) begin
			res_reused_q  <= (type_q == REQ_ACQUIRE) && found_q;
			if (type_q == REQ_RECYCLE) begin
				res_granted_q <= '0;
			end else begin
				res_granted_q <= found_q ? best_cap_q : size_q;
			end
			res_kept_q    <= kept_q;
			res_evicted_q <= COUNT_W'(evict_q);
			res_entries_q <= COUNT_W'(count_q);
			res_total_q   <= held_q;
		end
	end

	assign res_reused  = res_reused_q;
	assign res_granted = res_granted_q;
	assign res_kept    = res_kept_q;
	assign res_evicted = res_evicted_q;
	assign res_entries = res_entries_q;
	assign res_total   = res_total_q;

endmodule

// File: test/buffer_pool_best_fit_tb.sv
// ----------------------------------------------------------------------------
// buffer_pool_best_fit_tb
// Drives acquire and recycle words into the best-fit buffer pool and checks
// each result word against a behavioral pool kept in the testbench. A short
// table covers the range edges, ties, the doubling bound and the register
// corner cases. Randomized phases follow under several register settings,
// with bursty requests and a stalling result sink.
// ----------------------------------------------------------------------------
module buffer_pool_best_fit_tb;
	import bpbf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_WORDS  = 100;
	localparam int PHASE_COUNT  = 7;
	localparam int RECENT_DEPTH = 16;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

	typedef struct packed {
		logic               reused;
		logic [DATA_W-1:0]  granted;
		logic               kept;
		logic [COUNT_W-1:0] evicted;
		logic [COUNT_W-1:0] entries;
		logic [DATA_W-1:0]  total;
	} pool_result_t;

	typedef enum logic [1:0] {ROW_ACQUIRE, ROW_RECYCLE, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [DATA_W-1:0]    value;
		bit                   pinned;
		pool_result_t         result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bpbf_req_if req_if();
	bpbf_rsp_if rsp_if();
	bpbf_cfg_if cfg_if();

	buffer_pool_best_fit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// behavioral pool
	logic [DATA_W-1:0] pool_caps [MAX_ENTRIES] = '{default: '0};
	int                pool_len = 0;
	logic [DATA_W-1:0] pool_bytes = '0;
	logic [DATA_W-1:0] min_bytes = MIN_POOLED_RESET;
	logic [DATA_W-1:0] budget = MAX_POOLED_RESET;

	pool_result_t      pending [$];
	stim_row_t         directed_rows [$];
	logic [DATA_W-1:0] recent_caps [$];

	bit           word_pinned;
	pool_result_t word_pin;
	int           errors = 0;
	int           word_count = 0;
	int           burst_left;
	int           idle_cycles = 0;
	logic [15:0]  stall_pattern = 16'hFFFF;
	int           pattern_age = 0;

	always #5 clk = ~clk;

	function automatic pool_result_t serve_request(logic kind, logic [DATA_W-1:0] size);
		pool_result_t      r;
		int                best;
		int                ev;
		int                i;
		logic [DATA_W:0]   held;
		logic [DATA_W:0]   upper;
		logic [DATA_W-1:0] c;
		r = '0;
		if (kind == REQ_ACQUIRE) begin
			r.granted = size;
			if (size >= min_bytes) begin
				upper = {size, 1'b0};
				best = -1;
				for (i = 0; i < pool_len; i++) begin
					c = pool_caps[i];
					if (c >= size && {1'b0, c} <= upper && (best < 0 || c < pool_caps[best]))
						best = i;
				end
				if (best >= 0) begin
					r.granted = pool_caps[best];
					r.reused = 1'b1;
					pool_bytes = pool_bytes - pool_caps[best];
					for (i = best; i < pool_len - 1; i++)
						pool_caps[i] = pool_caps[i + 1];
					pool_len--;
				end
			end
		end else if (size >= min_bytes && size <= (budget >> 2)) begin
			held = {1'b0, pool_bytes};
			ev = 0;
			while (ev < pool_len &&
			       (pool_len - ev >= MAX_ENTRIES || held + size > {1'b0, budget})) begin
				held = held - pool_caps[ev];
				ev++;
			end
			for (i = 0; i < pool_len - ev; i++)
				pool_caps[i] = pool_caps[i + ev];
			pool_len = pool_len - ev;
			pool_caps[pool_len] = size;
			pool_len++;
			pool_bytes = held[DATA_W-1:0] + size;
			r.kept = 1'b1;
			r.evicted = ev[COUNT_W-1:0];
		end
		r.entries = pool_len[COUNT_W-1:0];
		r.total = pool_bytes;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
	                               logic [DATA_W-1:0] want);
		errors++;
		if (errors <= 100)
			$display("mismatch %s: got %h want %h (words in %0d)", what, got, want, word_count);
	endtask

	task automatic compare_result(pool_result_t got, pool_result_t want);
		if (got.reused !== want.reused)
			report_mismatch("reused", DATA_W'(got.reused), DATA_W'(want.reused));
		if (got.granted !== want.granted)
			report_mismatch("granted_capacity", got.granted, want.granted);
		if (got.kept !== want.kept)
			report_mismatch("kept", DATA_W'(got.kept), DATA_W'(want.kept));
		if (got.evicted !== want.evicted)
			report_mismatch("evicted_count", DATA_W'(got.evicted), DATA_W'(want.evicted));
		if (got.entries !== want.entries)
			report_mismatch("entry_count", DATA_W'(got.entries), DATA_W'(want.entries));
		if (got.total !== want.total)
			report_mismatch("pooled_total", got.total, want.total);
	endtask

	function automatic stim_row_t req_row(row_kind_t kind, logic [DATA_W-1:0] size);
		stim_row_t r;
		r.kind = kind;
		r.reg_idx = '0;
		r.value = size;
		r.pinned = 1'b0;
		r.result = '0;
		return r;
	endfunction

	function automatic stim_row_t pinned_row(row_kind_t kind, logic [DATA_W-1:0] size,
	                                         pool_result_t result);
		stim_row_t r;
		r = req_row(kind, size);
		r.pinned = 1'b1;
		r.result = result;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		stim_row_t r;
		r = req_row(ROW_CONFIG, value);
		r.reg_idx = idx;
		return r;
	endfunction

	function automatic void add_row(stim_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic logic [DATA_W-1:0] pick_size(logic kind);
		logic [DATA_W-1:0] keep_hi;
		logic [DATA_W-1:0] c;
		int                roll;
		keep_hi = budget >> 2;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			case ($urandom_range(0, 5))
				0: return '0;
				1: return '1;
				2: return min_bytes;
				3: return min_bytes - 1;
				4: return keep_hi;
				default: return keep_hi + 1;
			endcase
		end
		if (roll < 18)
			return $urandom();
		if (kind == REQ_ACQUIRE && recent_caps.size() != 0) begin
			c = recent_caps[$urandom_range(0, recent_caps.size() - 1)];
			return c - $urandom_range(0, c >> 1);
		end
		if (min_bytes <= keep_hi) begin
			if ($urandom_range(0, 2) == 0)
				return min_bytes + $urandom_range(0, keep_hi - min_bytes);
			return min_bytes + $urandom_range(0, (keep_hi - min_bytes) >> 3);
		end
		return $urandom_range(0, 1000);
	endfunction

	task automatic send_request(logic kind, logic [DATA_W-1:0] size, bit pinned,
	                            pool_result_t pin);
		if (burst_left == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
		end
		burst_left--;
		req_if.valid    <= 1'b1;
		req_if.req_type <= kind;
		req_if.req_size <= size;
		word_pinned     <= pinned;
		word_pin        <= pin;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		burst_left = 0;
	endtask

	// result sink: rotate a stall pattern, swap it now and then
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : ($urandom() | 16'h1);
			pattern_age <= $urandom_range(16, 96);
			rsp_if.ready <= stall_pattern[0];
		end else begin
			stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
			pattern_age <= pattern_age - 1;
			rsp_if.ready <= stall_pattern[0];
		end
	end

	always @(posedge clk) begin : scoreboard
		pool_result_t got;
		pool_result_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got = {rsp_if.reused, rsp_if.granted_capacity, rsp_if.kept,
				       rsp_if.evicted_count, rsp_if.entry_count, rsp_if.pooled_total};
				if (pending.size() == 0) begin
					report_mismatch("result with none pending", '0, '0);
				end else begin
					want = pending.pop_front();
					compare_result(got, want);
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				if (cfg_if.index == REG_MIN_POOLED)
					min_bytes = cfg_if.data;
				else if (cfg_if.index == REG_MAX_POOLED)
					budget = cfg_if.data;
			end
			if (req_if.valid && req_if.ready) begin
				want = serve_request(req_if.req_type, req_if.req_size);
				if (word_pinned)
					want = word_pin;
				pending.insert(pending.size(), want);
				word_count++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
			    (cfg_if.valid && cfg_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic              kind;
		logic [DATA_W-1:0] size;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_ACQUIRE;
		req_if.req_size = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MIN_POOLED;
		cfg_if.data = '0;
		word_pinned = 1'b0;
		word_pin = '0;
		burst_left = 0;

		add_row(pinned_row(ROW_ACQUIRE, 32'h0020_0000,
			pool_result_t'{1'b0, 32'h0020_0000, 1'b0, 6'd0, 6'd0, 32'd0}));
		add_row(pinned_row(ROW_ACQUIRE, 32'h0,
			pool_result_t'{1'b0, 32'h0, 1'b0, 6'd0, 6'd0, 32'd0}));
		add_row(pinned_row(ROW_ACQUIRE, 32'hFFFF_FFFF,
			pool_result_t'{1'b0, 32'hFFFF_FFFF, 1'b0, 6'd0, 6'd0, 32'd0}));
		add_row(pinned_row(ROW_RECYCLE, 32'h0,
			pool_result_t'{1'b0, 32'h0, 1'b0, 6'd0, 6'd0, 32'd0}));
		add_row(pinned_row(ROW_RECYCLE, 32'hFFFF_FFFF,
			pool_result_t'{1'b0, 32'h0, 1'b0, 6'd0, 6'd0, 32'd0}));
		add_row(pinned_row(ROW_RECYCLE, 32'h0010_0000,
			pool_result_t'{1'b0, 32'h0, 1'b1, 6'd0, 6'd1, 32'h0010_0000}));
		add_row(pinned_row(ROW_RECYCLE, 32'h0A00_0000,
			pool_result_t'{1'b0, 32'h0, 1'b1, 6'd0, 6'd2, 32'h0A10_0000}));
		add_row(pinned_row(ROW_RECYCLE, 32'h0A00_0001,
			pool_result_t'{1'b0, 32'h0, 1'b0, 6'd0, 6'd2, 32'h0A10_0000}));
		add_row(req_row(ROW_RECYCLE, 32'h0030_0000));
		add_row(req_row(ROW_RECYCLE, 32'h0030_0000));
		add_row(req_row(ROW_RECYCLE, 32'h0020_0000));
		add_row(req_row(ROW_ACQUIRE, 32'h0020_0000));
		add_row(req_row(ROW_ACQUIRE, 32'h0020_0000));
		add_row(req_row(ROW_ACQUIRE, 32'h8000_0000));
		add_row(req_row(ROW_ACQUIRE, 32'h0010_0000));
		repeat (4)
			add_row(req_row(ROW_RECYCLE, 32'h0A00_0000));
		add_row(cfg_row(REG_MAX_POOLED, 32'h1000_0000));
		add_row(req_row(ROW_RECYCLE, 32'h0400_0000));
		add_row(cfg_row(REG_MIN_POOLED, 32'h0));
		add_row(req_row(ROW_RECYCLE, 32'h0));
		add_row(req_row(ROW_ACQUIRE, 32'h0));
		add_row(cfg_row(REG_MIN_POOLED, 32'hFFFF_FFFF));
		add_row(req_row(ROW_RECYCLE, 32'h0400_0000));
		add_row(req_row(ROW_ACQUIRE, 32'hFFFF_FFFF));
		add_row(cfg_row(REG_UNUSED_LO, 32'h0));
		add_row(cfg_row(REG_UNUSED_HI, 32'h0));
		add_row(cfg_row(REG_MIN_POOLED, 32'h0));
		add_row(cfg_row(REG_MAX_POOLED, 32'hFFFF_FFFF));
		add_row(req_row(ROW_RECYCLE, 32'h3FFF_FFFF));
		add_row(req_row(ROW_RECYCLE, 32'h4000_0000));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_CONFIG)
				write_register(directed_rows[n].reg_idx, directed_rows[n].value);
			else
				send_request((directed_rows[n].kind == ROW_RECYCLE) ? REQ_RECYCLE : REQ_ACQUIRE,
				             directed_rows[n].value, directed_rows[n].pinned,
				             directed_rows[n].result);
		end

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin lo = MIN_POOLED_RESET; hi = MAX_POOLED_RESET; end
				1: begin lo = 32'd4096;         hi = 32'h0010_0000;    end
				2: begin lo = 32'd1;            hi = 32'hFFFF_FFFF;    end
				3: begin lo = 32'd0;            hi = 32'd0;            end
				4: begin lo = 32'hFFFF_FFFF;    hi = 32'hFFFF_FFFF;    end
				5: begin lo = 32'd100;          hi = 32'd4000;         end
				default: begin
					lo = $urandom() >> $urandom_range(0, 31);
					hi = $urandom();
				end
			endcase
			write_register(REG_MIN_POOLED, lo);
			write_register(REG_MAX_POOLED, hi);
			recent_caps.delete();
			repeat (PHASE_WORDS) begin
				kind = ($urandom_range(0, 99) < 55) ? REQ_RECYCLE : REQ_ACQUIRE;
				size = pick_size(kind);
				if (kind == REQ_RECYCLE) begin
					recent_caps.insert(recent_caps.size(), size);
					if (recent_caps.size() > RECENT_DEPTH)
						void'(recent_caps.pop_front());
				end
				send_request(kind, size, 1'b0, '0);
			end
		end

		req_if.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
